>>> design/idat_chunk_framer_crc32_unit_defines.svh
// Assertion macros shared by the IDAT framer checker.
`ifndef IDAT_CHUNK_FRAMER_CRC32_UNIT_DEFINES_SVH
`define IDAT_CHUNK_FRAMER_CRC32_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDAT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idat framer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IDAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idat framer check failed");

`endif

>>> design/idat_pkg.sv
// Constants, codes and helper functions for the IDAT chunk framer.
package idat_pkg;

    // Input action codes (carried in tuser)
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;
    localparam logic [1:0] ACT_RSVD  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_OUTSIDE    = 2'd1;
    localparam logic [1:0] STAT_INCOMPLETE = 2'd2;

    localparam logic [31:0] IDAT_TAG  = 32'h4944_4154;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    // Running CRC after the four type bytes, before final inversion
    localparam logic [31:0] CRC_IDAT_RUN = 32'hCA50_F9E1;
    localparam logic [47:0] CNT_MAX   = 48'hFFFF_FFFF_FFFF;

    // Beat positions inside one item
    localparam logic [3:0] IDX_FIRST    = 4'd0;
    localparam logic [3:0] IDX_HDR_LAST = 4'd7;
    localparam logic [3:0] IDX_CRC_LAST = 4'd11;
    localparam logic [3:0] IDX_TRL_LAST = 4'd4;

    typedef logic [7:0] byte_t;

    // One byte through the reflected CRC-32, eight bit steps
    function automatic logic [31:0] crc_feed(input logic [31:0] c, input byte_t b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Big-endian byte pick: lane 0 is the most significant byte
    function automatic byte_t be_byte(input logic [31:0] w, input logic [1:0] lane);
        byte_t r;
        case (lane)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

endpackage

>>> design/idat_chunk_framer_crc32_unit.sv
// IDAT chunk framer top level: item register, beat sequencer, output register.
//
// Wraps a byte stream into PNG IDAT chunks with a reflected CRC-32. Each input
// beat is held in an item register and its framed beats leave one per cycle,
// unless the output stalls, through an output register. A data beat inside a
// chunk yields one beat, so data streams at one byte per clock unless stalled;
// the beat that closes a chunk yields five beats (byte plus four CRC bytes), a
// start beat yields eight (length and type bytes), twelve for a zero-length
// chunk, and an end beat or a stray data beat yields one. Item time is set by
// its beat count at the single output port; the CRC update for one byte is one
// combinational stage. Action code 3 is taken and dropped without output.
module idat_chunk_framer_crc32_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // chunk_length[31:0], data_byte[39:32]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_byte[7:0], status[9:8],
                                        // total_bytes[57:10], zero[63:58]
    output logic        m_axis_tuser,   // byte_valid[0]
    output logic        m_axis_tlast
);
    import idat_pkg::*;

    // item register
    logic        item_valid_reg;
    logic [1:0]  act_reg;
    logic [31:0] len_reg;
    byte_t       db_reg;
    logic [3:0]  idx_reg;

    // framing state
    logic [31:0] bytes_left_reg;
    logic        chunk_open_reg;
    logic [31:0] crc_reg;
    logic [47:0] wcount_reg;

    // output register
    logic        m_valid_reg;
    byte_t       m_byte_reg;
    logic        m_bv_reg;
    logic [1:0]  m_status_reg;
    logic [47:0] m_total_reg;
    logic        m_last_reg;

    byte_t       res_byte;
    logic        res_bv;
    logic [1:0]  res_status;
    logic        res_last;
    logic [31:0] crc_fed;
    logic [47:0] wcount_next;
    logic        adv;
    logic        load;
    logic [1:0]  open_status;

    assign adv  = item_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || (adv && res_last);
    assign load = s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_RSVD);

    assign crc_fed     = crc_feed(crc_reg, db_reg);
    assign open_status = chunk_open_reg ? STAT_INCOMPLETE : STAT_OK;

    // beat generation for the held item
    always_comb
    begin
        res_byte   = '0;
        res_bv     = 1'b0;
        res_status = STAT_OK;
        res_last   = 1'b1;
        case (act_reg)
            ACT_START:
            begin
                res_bv     = 1'b1;
                res_status = open_status;
                case (idx_reg[3:2])
                    2'd0:    res_byte = be_byte(len_reg, idx_reg[1:0]);
                    2'd1:    res_byte = be_byte(IDAT_TAG, idx_reg[1:0]);
                    default: res_byte = be_byte(~CRC_IDAT_RUN, idx_reg[1:0]);
                endcase
                res_last = ((idx_reg == IDX_HDR_LAST) && (len_reg != '0))
                           || (idx_reg == IDX_CRC_LAST);
            end
            ACT_DATA:
            begin
                if (!chunk_open_reg)
                begin
                    res_status = STAT_OUTSIDE;
                end
                else if (idx_reg == IDX_FIRST)
                begin
                    res_bv   = 1'b1;
                    res_byte = db_reg;
                    res_last = (bytes_left_reg != 32'd1);
                end
                else
                begin
                    res_bv   = 1'b1;
                    res_byte = be_byte(~crc_reg, 2'(idx_reg - 4'd1));
                    res_last = (idx_reg == IDX_TRL_LAST);
                end
            end
            ACT_END:
            begin
                res_status = open_status;
            end
            default:
            begin
                res_last = 1'b1;
            end
        endcase
    end

    // saturating count of framed bytes
    assign wcount_next = (res_bv && (wcount_reg != CNT_MAX)) ? wcount_reg + 48'd1
                                                             : wcount_reg;

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
            bytes_left_reg <= '0;
            chunk_open_reg <= 1'b0;
            crc_reg        <= CRC_INIT;
            wcount_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (load)
            begin
                item_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end
            else if (adv)
            begin
                if (res_last)
                begin
                    item_valid_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 4'd1;
            end

            if (adv)
            begin
                // end of stream clears the count after reporting it
                wcount_reg <= (act_reg == ACT_END) ? '0 : wcount_next;
                case (act_reg)
                    ACT_START:
                    begin
                        if (res_last)
                        begin
                            crc_reg        <= (len_reg == '0) ? CRC_INIT : CRC_IDAT_RUN;
                            chunk_open_reg <= (len_reg != '0);
                            bytes_left_reg <= len_reg;
                        end
                    end
                    ACT_DATA:
                    begin
                        if (chunk_open_reg)
                        begin
                            if (idx_reg == IDX_FIRST)
                            begin
                                crc_reg        <= crc_fed;
                                bytes_left_reg <= bytes_left_reg - 32'd1;
                            end
                            else if (res_last)
                            begin
                                crc_reg        <= CRC_INIT;
                                chunk_open_reg <= 1'b0;
                                bytes_left_reg <= '0;
                            end
                        end
                    end
                    ACT_END:
                    begin
                        crc_reg        <= CRC_INIT;
                        chunk_open_reg <= 1'b0;
                        bytes_left_reg <= '0;
                    end
                    default:
                    begin
                        crc_reg <= crc_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            act_reg <= s_axis_tuser;
            len_reg <= s_axis_tdata[31:0];
            db_reg  <= s_axis_tdata[39:32];
        end
        if (adv)
        begin
            m_byte_reg   <= res_byte;
            m_bv_reg     <= res_bv;
            m_status_reg <= res_status;
            m_total_reg  <= wcount_next;
            m_last_reg   <= res_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, m_total_reg, m_status_reg, m_byte_reg};
    assign m_axis_tuser  = m_bv_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

>>> design/idat_chk.sv
// Port-level checker for the IDAT chunk framer, bound to the top level.
`include "idat_chunk_framer_crc32_unit_defines.svh"

module idat_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    import idat_pkg::*;

    // stalled output beat holds
    `IDAT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // a beat without a framed byte ends its item and carries a zero byte
    `IDAT_ASSERT_NOW(a_flag_only_last, m_axis_tvalid && !m_axis_tuser,
        m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))

    // stray data is never framed
    `IDAT_ASSERT_NOW(a_outside_no_byte,
        m_axis_tvalid && (m_axis_tdata[9:8] == STAT_OUTSIDE), !m_axis_tuser)

    // status code 3 and the pad bits never appear
    `IDAT_ASSERT_NOW(a_status_range, m_axis_tvalid,
        (m_axis_tdata[9:8] != 2'd3) && (m_axis_tdata[63:58] == 6'd0))

endmodule

bind idat_chunk_framer_crc32_unit idat_chk u_idat_chk (.*);
